// ----- rtl/keycode_to_character_translator_defines.svh -----
// ----------------------------------------------------------------------------
// keycode_to_character_translator_defines
// assertion macros for the keycode translator
// ----------------------------------------------------------------------------
`ifndef KEYCODE_TO_CHARACTER_TRANSLATOR_DEFINES_SVH
`define KEYCODE_TO_CHARACTER_TRANSLATOR_DEFINES_SVH

// a condition that must hold at every edge outside reset
`define KCT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// a cause followed by an effect in the next cycle
`define KCT_ASSERT_NEXT(label, clk, rst_n, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error(msg);

`endif

// ----- rtl/kct_pkg.sv -----
// ----------------------------------------------------------------------------
// kct_pkg
// types, constants and key tables shared by the keycode translator
// ----------------------------------------------------------------------------
package kct_pkg;

  localparam int unsigned TableEntriesDefault = 128;
  localparam int unsigned QueueDepthDefault   = 2;

  localparam logic [15:0] CodeExtPrefix   = 16'h00e0;
  localparam logic [15:0] CodePausePrefix = 16'h00e1;
  localparam logic [15:0] SpecialBit      = 16'h0080;
  localparam logic [15:0] FnBase          = 16'hf000;
  localparam logic [15:0] CtrlMask        = 16'h001f;
  localparam logic [15:0] ChDel           = 16'h007f;
  localparam logic [15:0] SpView          = 16'h0080;
  localparam logic [15:0] SpShift         = 16'h00e0;
  localparam logic [15:0] SpBreak         = 16'h00e1;
  localparam logic [15:0] SpCtrl          = 16'h00e2;
  localparam logic [15:0] SpAlt           = 16'h00e3;
  localparam logic [15:0] SpCaps          = 16'h00e4;
  localparam logic [15:0] SpNum           = 16'h00e5;
  localparam logic [15:0] ChUp            = 16'hf00e;

  typedef enum logic [1:0] {
    TblPlain = 2'd0,
    TblShift = 2'd1,
    TblExt   = 2'd2
  } tbl_sel_e;

  typedef struct packed {
    logic        is_key_event;
    logic [15:0] key_code;
    logic [1:0]  key_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] character;
    logic        reset_request;
  } out_item_t;

  // classified lookup travelling from front to back
  typedef struct packed {
    tbl_sel_e   tbl;
    logic [6:0] idx;
    logic       release_key;
  } lookup_t;

  function automatic logic [15:0] fn_code(input logic [7:0] n);
    return FnBase | {8'h00, n};
  endfunction

  // entries common to the plain and shifted tables
  function automatic logic [15:0] rom_common(input logic [6:0] a);
    logic [15:0] c;
    c = 16'h0000;
    case (a)
      7'h01: c = 16'h001b;
      7'h0e: c = 16'h0008;
      7'h0f: c = 16'h0009;
      7'h1c: c = 16'h000a;
      7'h1d: c = SpCtrl;
      7'h2a: c = SpShift;
      7'h36: c = SpShift;
      7'h37: c = 16'h002a;
      7'h38: c = SpAlt;
      7'h39: c = 16'h0020;
      7'h3a: c = SpCtrl;
      7'h3b: c = fn_code(8'd1);
      7'h3c: c = fn_code(8'd2);
      7'h3d: c = fn_code(8'd3);
      7'h3e: c = fn_code(8'd4);
      7'h3f: c = fn_code(8'd5);
      7'h40: c = fn_code(8'd6);
      7'h41: c = fn_code(8'd7);
      7'h42: c = fn_code(8'd8);
      7'h43: c = fn_code(8'd9);
      7'h44: c = fn_code(8'd10);
      7'h45: c = SpNum;
      7'h46: c = fn_code(8'd21);
      7'h47: c = 16'h0037;
      7'h48: c = 16'h0038;
      7'h49: c = 16'h0039;
      7'h4a: c = 16'h002d;
      7'h4b: c = 16'h0034;
      7'h4c: c = 16'h0035;
      7'h4d: c = 16'h0036;
      7'h4e: c = 16'h002b;
      7'h4f: c = 16'h0031;
      7'h50: c = 16'h0032;
      7'h51: c = 16'h0033;
      7'h52: c = 16'h0030;
      7'h53: c = 16'h002e;
      7'h57: c = fn_code(8'd11);
      7'h58: c = fn_code(8'd12);
      7'h7b: c = ChUp;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] rom_plain(input logic [6:0] a);
    logic [15:0] c;
    c = rom_common(a);
    case (a)
      7'h02: c = 16'h0031;
      7'h03: c = 16'h0032;
      7'h04: c = 16'h0033;
      7'h05: c = 16'h0034;
      7'h06: c = 16'h0035;
      7'h07: c = 16'h0036;
      7'h08: c = 16'h0037;
      7'h09: c = 16'h0038;
      7'h0a: c = 16'h0039;
      7'h0b: c = 16'h0030;
      7'h0c: c = 16'h002d;
      7'h0d: c = 16'h003d;
      7'h10: c = 16'h0071;
      7'h11: c = 16'h0077;
      7'h12: c = 16'h0065;
      7'h13: c = 16'h0072;
      7'h14: c = 16'h0074;
      7'h15: c = 16'h0079;
      7'h16: c = 16'h0075;
      7'h17: c = 16'h0069;
      7'h18: c = 16'h006f;
      7'h19: c = 16'h0070;
      7'h1a: c = 16'h005b;
      7'h1b: c = 16'h005d;
      7'h1e: c = 16'h0061;
      7'h1f: c = 16'h0073;
      7'h20: c = 16'h0064;
      7'h21: c = 16'h0066;
      7'h22: c = 16'h0067;
      7'h23: c = 16'h0068;
      7'h24: c = 16'h006a;
      7'h25: c = 16'h006b;
      7'h26: c = 16'h006c;
      7'h27: c = 16'h003b;
      7'h28: c = 16'h0027;
      7'h29: c = 16'h0060;
      7'h2b: c = 16'h005c;
      7'h2c: c = 16'h007a;
      7'h2d: c = 16'h0078;
      7'h2e: c = 16'h0063;
      7'h2f: c = 16'h0076;
      7'h30: c = 16'h0062;
      7'h31: c = 16'h006e;
      7'h32: c = 16'h006d;
      7'h33: c = 16'h002c;
      7'h34: c = 16'h002e;
      7'h35: c = 16'h002f;
      7'h79: c = SpView;
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] rom_shift(input logic [6:0] a);
    logic [15:0] c;
    c = rom_common(a);
    case (a)
      7'h02: c = 16'h0021;
      7'h03: c = 16'h0040;
      7'h04: c = 16'h0023;
      7'h05: c = 16'h0024;
      7'h06: c = 16'h0025;
      7'h07: c = 16'h005e;
      7'h08: c = 16'h0026;
      7'h09: c = 16'h002a;
      7'h0a: c = 16'h0028;
      7'h0b: c = 16'h0029;
      7'h0c: c = 16'h005f;
      7'h0d: c = 16'h002b;
      7'h10: c = 16'h0051;
      7'h11: c = 16'h0057;
      7'h12: c = 16'h0045;
      7'h13: c = 16'h0052;
      7'h14: c = 16'h0054;
      7'h15: c = 16'h0059;
      7'h16: c = 16'h0055;
      7'h17: c = 16'h0049;
      7'h18: c = 16'h004f;
      7'h19: c = 16'h0050;
      7'h1a: c = 16'h007b;
      7'h1b: c = 16'h007d;
      7'h1e: c = 16'h0041;
      7'h1f: c = 16'h0053;
      7'h20: c = 16'h0044;
      7'h21: c = 16'h0046;
      7'h22: c = 16'h0047;
      7'h23: c = 16'h0048;
      7'h24: c = 16'h004a;
      7'h25: c = 16'h004b;
      7'h26: c = 16'h004c;
      7'h27: c = 16'h003a;
      7'h28: c = 16'h0022;
      7'h29: c = 16'h007e;
      7'h2b: c = 16'h007c;
      7'h2c: c = 16'h005a;
      7'h2d: c = 16'h0058;
      7'h2e: c = 16'h0043;
      7'h2f: c = 16'h0056;
      7'h30: c = 16'h0042;
      7'h31: c = 16'h004e;
      7'h32: c = 16'h004d;
      7'h33: c = 16'h003c;
      7'h34: c = 16'h003e;
      7'h35: c = 16'h003f;
      7'h79: c = ChUp;
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] rom_ext(input logic [6:0] a);
    logic [15:0] c;
    c = 16'h0000;
    case (a)
      7'h1c: c = 16'h000a;
      7'h1d: c = SpCtrl;
      7'h2a: c = SpShift;
      7'h35: c = 16'h002f;
      7'h37: c = fn_code(8'd16);
      7'h38: c = SpAlt;
      7'h46: c = SpBreak;
      7'h47: c = fn_code(8'd13);
      7'h48: c = ChUp;
      7'h49: c = fn_code(8'd15);
      7'h4b: c = fn_code(8'd17);
      7'h4d: c = fn_code(8'd18);
      7'h4f: c = 16'h000d;
      7'h50: c = SpView;
      7'h51: c = fn_code(8'd19);
      7'h52: c = fn_code(8'd20);
      7'h53: c = ChDel;
      7'h79: c = ChUp;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/kct_front.sv -----
// ----------------------------------------------------------------------------
// kct_front
// accepts key events, tracks prefixes and picks the table for each lookup
// ----------------------------------------------------------------------------
module kct_front #(
  parameter int unsigned TableEntries = kct_pkg::TableEntriesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  kct_pkg::in_item_t item_i,
  output logic              push_o,
  output kct_pkg::lookup_t  lookup_o
);

  logic       ext_q, ext_d;
  logic [1:0] skip_q, skip_d;
  logic       in_range;

  // codes at or above TableEntries, other than the prefixes, push no lookup
  assign in_range = (item_i.key_code < 16'(TableEntries));

  always_comb begin
    ext_d          = ext_q;
    skip_d         = skip_q;
    push_o         = 1'b0;
    lookup_o.idx   = item_i.key_code[6:0];
    lookup_o.release_key = (item_i.key_value == 2'd0);
    // plain or shifted is settled in the back, where shift is current
    lookup_o.tbl   = kct_pkg::TblPlain;
    if (valid_i && item_i.is_key_event) begin
      if (item_i.key_code == kct_pkg::CodeExtPrefix) begin
        ext_d = 1'b1;
      end else if (item_i.key_code == kct_pkg::CodePausePrefix) begin
        skip_d = 2'd2;
      end else if (in_range) begin
        if (ext_q) begin
          ext_d        = 1'b0;
          lookup_o.tbl = kct_pkg::TblExt;
          push_o       = 1'b1;
        end else if (skip_q != 2'd0) begin
          skip_d = skip_q - 2'd1;
        end else begin
          push_o = 1'b1;
        end
      end
    end
    if (item_i.key_code[15:7] != 9'd0) begin
      lookup_o.idx = 7'h00; // codes of 128 and above read as empty
      if (lookup_o.tbl != kct_pkg::TblExt) lookup_o.tbl = kct_pkg::TblExt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q  <= 1'b0;
      skip_q <= 2'd0;
    end else begin
      ext_q  <= ext_d;
      skip_q <= skip_d;
    end
  end

endmodule

// ----- rtl/kct_queue.sv -----
// ----------------------------------------------------------------------------
// kct_queue
// small fifo for lookups between front and back
// ----------------------------------------------------------------------------
module kct_queue #(
  parameter int unsigned Depth = kct_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  kct_pkg::lookup_t data_i,
  output logic             full_o,
  output logic             empty_o,
  input  logic             pop_i,
  output kct_pkg::lookup_t data_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  kct_pkg::lookup_t mem_q [Depth];
  logic [Aw-1:0] wr_q, rd_q;
  logic [Aw:0]   cnt_q;

  assign full_o  = (cnt_q == (Aw+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (Aw+1)'(push_i && !full_o) - (Aw+1)'(pop_i && !empty_o);
    end
  end

endmodule

// ----- rtl/kct_back.sv -----
// ----------------------------------------------------------------------------
// kct_back
// reads the key tables, keeps modifier state and builds result transactions
// ----------------------------------------------------------------------------
module kct_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  kct_pkg::lookup_t   lookup_i,
  output logic               take_o,
  output logic               empty_o,
  input  logic               pop_i,
  output kct_pkg::out_item_t item_o
);

  logic shift_q, shift_d, ctrl_q, ctrl_d, alt_q, alt_d, caps_q, caps_d;
  logic out_vld_q, out_vld_d;
  kct_pkg::out_item_t out_q, out_d;
  logic [15:0] c;
  logic        emit;

  assign empty_o      = !out_vld_q;
  assign item_o       = out_q;
  // output register may refill in the cycle it is drained
  assign take_o       = valid_i && (!out_vld_q || pop_i);

  always_comb begin
    case (lookup_i.tbl)
      kct_pkg::TblPlain: c = shift_q ? kct_pkg::rom_shift(lookup_i.idx)
                                     : kct_pkg::rom_plain(lookup_i.idx);
      kct_pkg::TblShift: c = kct_pkg::rom_shift(lookup_i.idx);
      kct_pkg::TblExt:   c = kct_pkg::rom_ext(lookup_i.idx);
      default:           c = 16'h0000;
    endcase
    if (caps_q && c >= 16'h0061 && c <= 16'h007a) c = c - 16'h0020;

    shift_d = shift_q;
    ctrl_d  = ctrl_q;
    alt_d   = alt_q;
    caps_d  = caps_q;
    emit    = 1'b0;
    out_d   = '{character: c, reset_request: 1'b0};
    if (lookup_i.release_key) begin
      if (c == kct_pkg::SpAlt) alt_d = 1'b0;
      else if (c == kct_pkg::SpShift) shift_d = 1'b0;
      else if (c == kct_pkg::SpCtrl) ctrl_d = 1'b0;
    end else if ((c & (kct_pkg::SpecialBit | kct_pkg::FnBase)) == 16'h0000) begin
      emit = 1'b1;
      if (ctrl_q) begin
        if (alt_q && c == kct_pkg::ChDel) begin
          out_d = '{character: 16'h0000, reset_request: 1'b1};
        end else begin
          out_d.character = c & kct_pkg::CtrlMask;
        end
      end
    end else begin
      case (c)
        kct_pkg::SpCaps:  caps_d  = !caps_q;
        kct_pkg::SpNum:   ;
        kct_pkg::SpShift: shift_d = 1'b1;
        kct_pkg::SpAlt:   alt_d   = 1'b1;
        kct_pkg::SpCtrl:  ctrl_d  = 1'b1;
        default:          emit    = 1'b1;
      endcase
    end

    out_vld_d = out_vld_q && !pop_i;
    if (take_o && emit) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q   <= 1'b0;
      ctrl_q    <= 1'b0;
      alt_q     <= 1'b0;
      caps_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (take_o) begin
        shift_q <= shift_d;
        ctrl_q  <= ctrl_d;
        alt_q   <= alt_d;
        caps_q  <= caps_d;
      end
    end
  end

endmodule

// ----- rtl/keycode_to_character_translator.sv -----
// keycode translator: key events in, characters out, both sides look like queues
//   input side : push with in_item_i, accepted while full is low
//   result side: out_item_o valid while empty is low, taken by pop
// each key event gives at most one result transaction; prefixes, releases,
// modifier presses and dropped codes give none
// on its way to the result ports an event passes the front stage register,
// the lookup queue and then the output register in the back end
// throughput: one event per cycle, sustained while the receiver keeps popping;
// the back end reads the key tables and updates modifiers once per cycle
// while its output register is free or drained; when the receiver stalls
// the output register holds, the back end stops, the lookup queue fills and
// full rises; full is high only while a staged event waits on a full queue
// reset clears all modifiers, prefix state, the queue and the output register
// ----------------------------------------------------------------------------
// keycode_to_character_translator
// scancode set 1 key events to characters with modifier tracking
// ----------------------------------------------------------------------------
`include "keycode_to_character_translator_defines.svh"

module keycode_to_character_translator #(
  parameter int unsigned TableEntries = kct_pkg::TableEntriesDefault,
  parameter int unsigned QueueDepth   = kct_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  kct_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output kct_pkg::out_item_t out_item_o
);

  // front stage register: one accepted event waits here for classification
  logic              stg_vld_q;
  kct_pkg::in_item_t stg_q;
  logic              front_push;
  kct_pkg::lookup_t  front_lookup;
  logic              q_full, q_empty, q_pop;
  kct_pkg::lookup_t  q_data;
  logic              stg_go;

  // the front only tracks prefixes; shift is applied in the back in queue
  // order, so the staged event moves on whenever the queue has room
  assign stg_go = stg_vld_q && !q_full;
  assign full   = stg_vld_q && !stg_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else if (push && !full) begin
      stg_vld_q <= 1'b1;
    end else if (stg_go) begin
      stg_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !full) stg_q <= in_item_i;
  end

  kct_front #(.TableEntries(TableEntries)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stg_go),
    .item_i      (stg_q),
    .push_o      (front_push),
    .lookup_o    (front_lookup)
  );

  kct_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .data_i (front_lookup),
    .full_o (q_full),
    .empty_o(q_empty),
    .pop_i  (q_pop),
    .data_o (q_data)
  );

  kct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (!q_empty),
    .lookup_i    (q_data),
    .take_o      (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .item_o      (out_item_o)
  );

  // a reset request never carries a character
  `KCT_ASSERT_ALWAYS(a_rst_req_no_char, clk_i, rst_ni,
    empty || !out_item_o.reset_request || out_item_o.character == 16'h0000,
    "reset request with a character")
  // a result not taken must hold
  `KCT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, !empty && !pop,
    !empty && $stable(out_item_o), "result changed while stalled")
  // the front pushes only when the queue has room
  `KCT_ASSERT_ALWAYS(a_front_room, clk_i, rst_ni, !front_push || !q_full,
    "lookup pushed into a full queue")

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// key events into the keycode translator, checked against an in-bench model
// ----------------------------------------------------------------------------
// a scoreboard class tracks modifier and prefix state and predicts each
// result transaction; directed sequences cover the corners, then random
// key sequences with random idling on both sides and one long result stall

module testbench;

  localparam int unsigned CycleLimit = 400000;

  // ------------------------------------------------------------------------
  // scoreboard: prediction of characters from key events
  // ------------------------------------------------------------------------
  class char_scoreboard;
    bit                   shift_on, ctrl_on, alt_on, caps_on, ext_armed;
    logic [1:0]           skip_left;
    kct_pkg::out_item_t   pending_chars[$];
    int                   errors;

    function void clear();
      shift_on = 0; ctrl_on = 0; alt_on = 0; caps_on = 0; ext_armed = 0;
      skip_left = 2'd0;
      pending_chars.delete();
      errors = 0;
    endfunction

    // note an accepted input transaction and queue what it should produce
    function void note_event(kct_pkg::in_item_t ev);
      logic [15:0]        ch;
      kct_pkg::out_item_t res;
      if (!ev.is_key_event) return;
      if (ev.key_code == kct_pkg::CodeExtPrefix) begin
        ext_armed = 1;
        return;
      end
      if (ev.key_code == kct_pkg::CodePausePrefix) begin
        skip_left = 2'd2;
        return;
      end
      if (ev.key_code >= 16'd128) return;
      if (ext_armed) begin
        ch = kct_pkg::rom_ext(ev.key_code[6:0]);
        ext_armed = 0;
      end else if (skip_left != 2'd0) begin
        skip_left = skip_left - 2'd1;
        return;
      end else if (shift_on) begin
        ch = kct_pkg::rom_shift(ev.key_code[6:0]);
      end else begin
        ch = kct_pkg::rom_plain(ev.key_code[6:0]);
      end
      if (caps_on && ch >= 16'h0061 && ch <= 16'h007a) ch = ch - 16'h0020;
      // a release only clears a modifier
      if (ev.key_value == 2'd0) begin
        if (ch == kct_pkg::SpAlt) alt_on = 0;
        else if (ch == kct_pkg::SpShift) shift_on = 0;
        else if (ch == kct_pkg::SpCtrl) ctrl_on = 0;
        return;
      end
      res.reset_request = 1'b0;
      if ((ch & (kct_pkg::SpecialBit | kct_pkg::FnBase)) == 16'h0000) begin
        if (ctrl_on) begin
          if (alt_on && ch == kct_pkg::ChDel) begin
            res.character = 16'h0000;
            res.reset_request = 1'b1;
            pending_chars.push_back(res);
            return;
          end
          ch = ch & kct_pkg::CtrlMask;
        end
      end else begin
        case (ch)
          kct_pkg::SpCaps: begin caps_on = !caps_on; return; end
          kct_pkg::SpNum: return;
          kct_pkg::SpShift: begin shift_on = 1; return; end
          kct_pkg::SpAlt: begin alt_on = 1; return; end
          kct_pkg::SpCtrl: begin ctrl_on = 1; return; end
          default: ;
        endcase
      end
      res.character = ch;
      pending_chars.push_back(res);
    endfunction

    // compare one accepted result transaction with the oldest prediction
    function void check_char(kct_pkg::out_item_t got);
      kct_pkg::out_item_t want;
      if (pending_chars.size() == 0) begin
        $error("unexpected result transaction: character %h reset_request %b",
               got.character, got.reset_request);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      if (got.character !== want.character) begin
        $error("character mismatch: expected %h actual %h", want.character, got.character);
        errors++;
      end
      if (got.reset_request !== want.reset_request) begin
        $error("reset_request mismatch: expected %b actual %b",
               want.reset_request, got.reset_request);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               pop = 1'b0;
  kct_pkg::in_item_t  in_item_i = '0;
  logic               full, empty;
  kct_pkg::out_item_t out_item_o;

  char_scoreboard keys_sb = new();
  int unsigned    cycle_count = 0;
  bit             stim_done = 0;
  // while set the receiver holds off so the block fills and stalls push
  bit             hold_off_req = 0;

  keycode_to_character_translator u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item_o)
  );

  // 10 time unit clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // monitor: both transaction kinds are sampled at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) keys_sb.note_event(in_item_i);
      if (pop && !empty) keys_sb.check_char(out_item_o);
    end
  end

  // receiver: random pop with gaps, plus a long hold-off on request
  initial begin : receiver
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        pop <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_off_req = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
    end
  end

  // one key event: held until accepted
  task automatic send_key(input bit is_key, input logic [15:0] code,
                          input logic [1:0] value, input bit allow_gap);
    int unsigned gap;
    gap = allow_gap ? gap_len() : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= '{is_key_event: is_key, key_code: code, key_value: value};
    do @(posedge clk_i); while (full);
  endtask

  task automatic press(input logic [15:0] code);
    send_key(1'b1, code, 2'd1, 1'b0);
  endtask

  task automatic release_key(input logic [15:0] code);
    send_key(1'b1, code, 2'd0, 1'b0);
  endtask

  // a code mostly from the populated table range
  function automatic logic [15:0] random_code();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return 16'($urandom_range(0, 127));
    if (r < 88) return kct_pkg::CodeExtPrefix;
    if (r < 92) return kct_pkg::CodePausePrefix;
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin : stimulus
    int unsigned n;
    keys_sb.clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: plain, shifted, extended and masked characters
    press(16'h001e);
    press(16'h0000);                    // empty entry gives character 0
    press(16'h0045);                    // num lock gives nothing
    send_key(1'b0, 16'hffff, 2'd3, 1'b0); // non-key event ignored
    press(16'hffff);                    // out of range dropped
    press(16'h0080);
    press(16'h002a); press(16'h0010); send_key(1'b1, 16'h0035, 2'd2, 1'b0);
    release_key(16'h002a);
    press(kct_pkg::CodeExtPrefix); press(16'h0048);
    press(kct_pkg::CodePausePrefix); press(16'h001d); press(16'h0045); press(16'h0011);
    // prefix overlap and repeated pause prefix
    press(kct_pkg::CodePausePrefix); press(kct_pkg::CodeExtPrefix); press(16'h0053);
    press(kct_pkg::CodePausePrefix); press(16'h0001); press(16'h0001); press(16'h0001);
    // ctrl masking then ctrl+alt+delete
    press(16'h001d); press(16'h001f); press(16'h0038);
    press(kct_pkg::CodeExtPrefix); press(16'h0053);
    release_key(16'h001d); release_key(16'h0038);
    press(16'h007f);

    // random: mostly valid key traffic, long result stall mid-way
    for (n = 0; n < 1200; n++) begin
      if (n == 400) hold_off_req = 1;
      send_key($urandom_range(0, 15) != 0, random_code(),
               2'($urandom_range(0, 3)), 1'b1);
      // keep modifiers from sticking for ever
      if ($urandom_range(0, 30) == 0) begin
        release_key(16'h002a); release_key(16'h001d); release_key(16'h0038);
      end
    end
    // all-ones fields
    send_key(1'b1, 16'hffff, 2'd3, 1'b0);
    push <= 1'b0;
    stim_done = 1;
  end

  initial begin : finisher
    wait (stim_done);
    @(posedge clk_i);
    while (keys_sb.pending_chars.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (keys_sb.errors == 0 && keys_sb.pending_chars.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
